### sv/sse_pkg.sv
// Shared types and constants for the shell sort engine.
// No dependencies; imported by shell_sort_engine and its bench.
package sse_pkg;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } item_word_t;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic               last_res;
        logic [15:0]        comparisons;
        logic [15:0]        shifts;
        logic               overflow;
    } res_word_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_HELD,
        ST_HOLD,
        ST_CMP,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_LD
    } sse_state_t;

endpackage

### sv/sse_store.sv
// Element store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module sse_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic signed [31:0]   wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic signed [31:0]   rdata
);

    logic signed [31:0] store_mem [DEPTH];
    logic signed [31:0] rdata_reg;

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/shell_sort_engine.sv
// Shell sort engine top level: load sequencer, sort sequencer, result register.
// Depends on sse_pkg and sse_store.
//
// Usage: words arrive on the item channel (item_valid/item_stall, payload item).
// Each word within DEPTH is written to the element store as it is accepted. A word with last set
// closes the set and starts the sort; words beyond DEPTH are dropped and the
// overflow bit of every result of that set is raised.
// The sort runs Shell sort with gaps n/2, n/4 .. 1 on the store (one write port, one read port).
// Each insertion step reads the held element (ST_RD_HELD, ST_HOLD), then takes one
// ST_CMP step per comparison, plus ST_PLACE when the element ends up at the front
// of its chain; the store's one read port sets this order. item_stall is high
// during sort and emission.
// Results leave on the res channel (res_valid/res_stall, payload res); each
// word takes a read of the store, then a load of the result register. While the
// receiver stalls, the result register holds and emission pauses. After the
// final word is loaded the block takes new items at once, even while that
// word still waits to be taken.
// Reset: element count, counters, overflow flag and res_valid clear; store
// contents are left as they are.
module shell_sort_engine
    import sse_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_word_t item,
    output logic       res_valid,
    input  logic       res_stall,
    output res_word_t  res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sse_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, n_next;
    logic [AW-1:0] gap_reg, gap_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] k_reg, k_next;
    logic [15:0]   cmp_reg, cmp_next;
    logic [15:0]   shf_reg, shf_next;
    logic          ovf_reg, ovf_next;
    logic signed [31:0] held_reg, held_next;
    logic          res_valid_reg, res_valid_next;
    res_word_t     res_reg, res_next;
    logic          load_out;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic signed [31:0] mem_rdata;

    logic [AW-1:0] j_minus;
    logic [AW-1:0] gap_half;
    logic [CW:0]   i_inc;
    logic [CW:0]   k_inc;
    logic [CW:0]   n_ext;

    sse_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign j_minus  = j_reg - gap_reg;
    assign gap_half = gap_reg >> 1;
    assign i_inc    = (CW + 1)'(i_reg) + (CW + 1)'(1);
    assign k_inc    = (CW + 1)'(k_reg) + (CW + 1)'(1);
    assign n_ext    = {1'b0, n_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            n_reg         <= '0;
            gap_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            cmp_reg       <= '0;
            shf_reg       <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            gap_reg       <= gap_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            cmp_reg       <= cmp_next;
            shf_reg       <= shf_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        if (load_out)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        n_next     = n_reg;
        gap_next   = gap_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cmp_next   = cmp_reg;
        shf_next   = shf_reg;
        ovf_next   = ovf_reg;
        held_next  = held_reg;
        mem_we     = 1'b0;
        mem_waddr  = j_reg;
        mem_wdata  = held_reg;
        mem_re     = 1'b0;
        mem_raddr  = i_reg;
        load_out   = 1'b0;

        res_next.value_res   = mem_rdata;
        res_next.last_res    = (k_inc == n_ext);
        res_next.comparisons = cmp_reg;
        res_next.shifts      = shf_reg;
        res_next.overflow    = ovf_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_valid)
                begin
                    if (count_reg < CW'(DEPTH))
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        mem_wdata  = item.value;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        n_next   = count_next;
                        gap_next = AW'(count_next >> 1);
                        i_next   = AW'(count_next >> 1);
                        k_next   = '0;
                        cmp_next = '0;
                        shf_next = '0;
                        if (gap_next == '0)
                        begin
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            state_next = ST_RD_HELD;
                        end
                    end
                end
            end

            ST_RD_HELD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = i_reg;
                state_next = ST_HOLD;
            end

            ST_HOLD:
            begin
                held_next  = mem_rdata;
                j_next     = i_reg;
                mem_re     = 1'b1;
                mem_raddr  = i_reg - gap_reg;
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                if (cmp_reg != CNT_MAX)
                begin
                    cmp_next = cmp_reg + 16'd1;
                end
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                if (mem_rdata > held_reg)
                begin
                    // move the larger element up by one gap
                    mem_wdata = mem_rdata;
                    if (shf_reg != CNT_MAX)
                    begin
                        shf_next = shf_reg + 16'd1;
                    end
                    j_next = j_minus;
                    if (j_minus >= gap_reg)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = j_minus - gap_reg;
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    mem_wdata = held_reg;
                    if (i_inc < n_ext)
                    begin
                        i_next     = i_reg + AW'(1);
                        state_next = ST_RD_HELD;
                    end
                    else if (gap_half == '0)
                    begin
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        gap_next   = gap_half;
                        i_next     = gap_half;
                        state_next = ST_RD_HELD;
                    end
                end
            end

            ST_PLACE:
            begin
                // held element reached the front of its chain
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = held_reg;
                if (i_inc < n_ext)
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = ST_RD_HELD;
                end
                else if (gap_half == '0)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    gap_next   = gap_half;
                    i_next     = gap_half;
                    state_next = ST_RD_HELD;
                end
            end

            ST_EMIT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = k_reg;
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    load_out = 1'b1;
                    if (k_inc == n_ext)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    assign item_stall = (state_reg != ST_LOAD);
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    a_cmp_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (j_reg >= gap_reg) && (gap_reg != '0))
        else $error("comparison outside gapped chain");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_HELD) |-> ((CW + 1)'(i_reg) < n_ext) && (gap_reg != '0))
        else $error("insertion index out of range");

    a_shift_le_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        shf_reg <= cmp_reg)
        else $error("more shifts than comparisons");

endmodule

### dv/shell_sort_engine_tb.sv
// Self-checking bench for shell_sort_engine: sends sets of signed words, predicts
// the sorted output with its comparison and shift counts, and checks every result word.
// Depends on sse_pkg and the shell_sort_engine RTL.
`timescale 1ns / 100ps

module shell_sort_engine_tb
    import sse_pkg::*;
();

    localparam int SET_DEPTH      = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;  // well above the longest 64-word sort

    typedef logic signed [31:0] elem_t;

    localparam elem_t ELEM_MIN = 32'sh8000_0000;
    localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;

    class shell_sort_scoreboard;
        elem_t       held[SET_DEPTH];
        int unsigned held_count;
        bit          dropped;
        res_word_t   sorted_words_q[$];
        int unsigned mismatches;
        int unsigned sets_sorted;
        int unsigned overflow_sets;
        int unsigned words_in;
        int unsigned words_out;

        // Stores the word and, when it closes a set, sorts and queues the results.
        function void note_element(item_word_t w);
            int        gap;
            int        i;
            int        j;
            int        n;
            elem_t     pick;
            bit        moving;
            logic [15:0] cmp;
            logic [15:0] shf;
            res_word_t r;
            words_in++;
            if (held_count < SET_DEPTH) begin
                held[held_count] = w.value;
                held_count++;
            end
            else begin
                dropped = 1'b1;
            end
            if (w.last) begin
                n = held_count;
                cmp = '0;
                shf = '0;
                for (gap = n / 2; gap > 0; gap = gap / 2) begin
                    for (i = gap; i < n; i++) begin
                        pick = held[i];
                        j = i;
                        moving = 1'b1;
                        while (moving && j >= gap) begin
                            if (cmp != CNT_MAX) cmp++;
                            if (held[j - gap] > pick) begin
                                held[j] = held[j - gap];
                                if (shf != CNT_MAX) shf++;
                                j -= gap;
                            end
                            else begin
                                moving = 1'b0;
                            end
                        end
                        held[j] = pick;
                    end
                end
                for (i = 0; i < n; i++) begin
                    r.value_res   = held[i];
                    r.last_res    = (i == n - 1);
                    r.comparisons = cmp;
                    r.shifts      = shf;
                    r.overflow    = dropped;
                    sorted_words_q.push_back(r);
                end
                sets_sorted++;
                if (dropped) overflow_sets++;
                held_count = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_sorted_word(res_word_t got);
            res_word_t exp;
            words_out++;
            if (sorted_words_q.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing expected:", $time);
                $display("%0t:   value=%0d last=%0b cmp=%0d shf=%0d ovf=%0b",
                         $time, got.value_res, got.last_res, got.comparisons, got.shifts,
                         got.overflow);
            end
            else begin
                exp = sorted_words_q.pop_front();
                if (got.value_res !== exp.value_res || got.last_res !== exp.last_res ||
                    got.comparisons !== exp.comparisons || got.shifts !== exp.shifts ||
                    got.overflow !== exp.overflow) begin
                    mismatches++;
                    $display("%0t: mismatch: expected value=%0d last=%0b cmp=%0d %s",
                             $time, exp.value_res, exp.last_res, exp.comparisons,
                             $sformatf("shf=%0d ovf=%0b", exp.shifts, exp.overflow));
                    $display("%0t:           actual value=%0d last=%0b cmp=%0d %s",
                             $time, got.value_res, got.last_res, got.comparisons,
                             $sformatf("shf=%0d ovf=%0b", got.shifts, got.overflow));
                end
            end
        endfunction

        function int unsigned pending();
            return sorted_words_q.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    item_word_t item;
    logic       res_valid;
    logic       res_stall;
    res_word_t  res;

    shell_sort_scoreboard sb;
    elem_t       set_buf[$];
    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned hold_requests;
    int unsigned idle_cycles;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    shell_sort_engine #(
        .DEPTH(SET_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    // Monitor and watchdog: both channels sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((item_valid && !item_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (item_valid && !item_stall) sb.note_element(item);
            if (res_valid && !res_stall) sb.check_sorted_word(res);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: no word moved for %0d cycles", $time, idle_cycles);
                $display("shell_sort_engine_tb: done, errors");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int unsigned served;
        int unsigned hold_left;
        served = 0;
        hold_left = 0;
        res_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left == 0 && served != hold_requests) begin
                served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else begin
                res_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
            end
        end
    end

    task automatic send_word(input elem_t v, input logic is_last);
        item_word_t w;
        item_word_t noise;
        w.value = v;
        w.last  = is_last;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            noise.value = $urandom;
            noise.last  = 1'($urandom_range(0, 1));
            @(negedge clk);
            item_valid <= 1'b0;
            item       <= noise;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall) @(posedge clk);
    endtask

    task automatic send_set();
        int k;
        for (k = 0; k < set_buf.size(); k++)
            send_word(set_buf[k], k == set_buf.size() - 1);
    endtask

    // Sender goes quiet until every predicted word has come back.
    task automatic quiesce();
        @(negedge clk);
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned n_words, input int unsigned snd_pct,
                             input int unsigned rcv_pct, input int unsigned first_len);
        int unsigned sent;
        int unsigned len;
        int unsigned sel;
        elem_t       v;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        sent = 0;
        while (sent < n_words) begin
            sel = $urandom_range(0, 79);
            if (sent == 0 && first_len != 0)
                len = first_len;
            else if (sel == 0)
                len = SET_DEPTH;
            else if (sel == 1)
                len = $urandom_range(SET_DEPTH + 1, SET_DEPTH + 6);
            else
                len = $urandom_range(1, 12);
            set_buf.delete();
            repeat (len) begin
                case ($urandom_range(0, 9))
                    0: v = ELEM_MIN;
                    1: v = ELEM_MAX;
                    2: v = $signed($urandom_range(0, 6)) - 3;  // forces duplicates
                    3: v = $signed($urandom_range(0, 6)) - 3;
                    default: v = $urandom;
                endcase
                set_buf.push_back(v);
            end
            send_set();
            sent += len;
        end
        quiesce();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        snd_idle_pct = 20;
        rcv_idle_pct = 50;
        hold_requests = 0;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: single words at both extremes, a pair, a triple, a reversed run, ties
        set_buf = '{ELEM_MIN};
        send_set();
        set_buf = '{ELEM_MAX};
        send_set();
        set_buf = '{ELEM_MAX, ELEM_MIN};
        send_set();
        set_buf = '{32'sd0, -32'sd1, 32'sd1};
        send_set();
        set_buf = '{32'sd7, 32'sd5, 32'sd3, 32'sd1, -32'sd1, -32'sd3, -32'sd5, -32'sd7};
        send_set();
        set_buf = '{32'sd5, 32'sd5, 32'sd5, 32'sd5};
        send_set();
        set_buf = '{ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MAX, 32'sd0};
        send_set();
        quiesce();

        run_phase(150, 36, 88, SET_DEPTH + 2);   // opens with an overflowing set
        run_phase(150, 88, 36, SET_DEPTH);       // opens with an exactly full set
        hold_requests++;                         // receiver backs off while words keep coming
        run_phase(150, 0, 0, 0);

        repeat (40) @(posedge clk);
        $display("run: %0d sets sorted (%0d overflowed), %0d words in, %0d words checked",
                 sb.sets_sorted, sb.overflow_sets, sb.words_in, sb.words_out);
        $display("run: %0d mismatches, %0d words still expected", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("shell_sort_engine_tb: done, clean");
        else
            $display("shell_sort_engine_tb: done, errors");
        $finish;
    end

endmodule
